### src/ellp_pkg.sv
package ellp_pkg;

    // default sizing of the matrix store
    localparam int MAX_ROWS_DEF = 32;
    localparam int SLOTS_DEF    = 8;

    // fixed-point format and field widths
    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 32;
    localparam int ACC_W     = 48;
    localparam int COL_W     = 5;
    localparam int NR_W      = 6;

    localparam logic [NR_W-1:0] N_ROWS_RST = 6'd32;

    // operation codes
    typedef enum logic [2:0] {
        OP_CLEAR     = 3'd0,
        OP_APPEND    = 3'd1,
        OP_APPEND_NZ = 3'd2,
        OP_WR_VEC    = 3'd3,
        OP_MUL_AX    = 3'd4,
        OP_MUL_XA    = 3'd5
    } t_op;

    typedef struct packed {
        logic [2:0]              op;
        logic [4:0]              row;
        logic [COL_W-1:0]        col;
        logic [4:0]              vec_index;
        logic signed [VAL_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [4:0]              out_index;
        logic signed [VAL_W-1:0] out_value;
        logic                    last;
        logic                    dropped;
    } t_out_word;

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic mul_en;   // capture product and old accumulator
        logic acc_vld;  // accumulator entry holds a value this run
    } t_mac_ctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APP_RD,
        S_APP_WR,
        S_ROW_RD,
        S_ROW_WT,
        S_ENT_RD,
        S_ENT_WT,
        S_MUL,
        S_ACC,
        S_OUT_RD,
        S_OUT_WT,
        S_OUT_HOLD
    } t_state;

    // clamp a wide accumulator to 32 bits
    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] a);
        logic sgn;
        sgn = a[ACC_W-1];
        if (a[ACC_W-1:VAL_W-1] == {(ACC_W-VAL_W+1){sgn}}) begin
            sat32 = a[VAL_W-1:0];
        end else if (sgn) begin
            sat32 = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            sat32 = {1'b0, {(VAL_W-1){1'b1}}};
        end
    endfunction

endpackage

### src/ellp_ram.sv
module ellp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/ellp_mac.sv
module ellp_mac (
    input  logic                              i_clk,
    input  ellp_pkg::t_mac_ctl                i_ctl,
    input  logic signed [ellp_pkg::VAL_W-1:0] i_a,
    input  logic signed [ellp_pkg::VAL_W-1:0] i_b,
    input  logic signed [ellp_pkg::ACC_W-1:0] i_acc,
    output logic signed [ellp_pkg::ACC_W-1:0] o_sum
);
    import ellp_pkg::*;

    localparam int PROD_W = 2 * VAL_W;
    localparam int SUM_W  = PROD_W + 1;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [PROD_W-1:0] term;
    logic signed [SUM_W-1:0]  sum;

    // stage 1: full product and the old accumulator
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_a * i_b;
            r_acc  <= i_ctl.acc_vld ? i_acc : '0;
        end
    end

    // stage 2: floor scaling, add, clamp to the accumulator range
    always_comb begin
        term = r_prod >>> FRAC_BITS;
        sum  = {{(SUM_W-ACC_W){r_acc[ACC_W-1]}}, r_acc} + {term[PROD_W-1], term};
        if (sum[SUM_W-1:ACC_W-1] == {(SUM_W-ACC_W+1){sum[SUM_W-1]}}) begin
            o_sum = sum[ACC_W-1:0];
        end else if (sum[SUM_W-1]) begin
            o_sum = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            o_sum = {1'b0, {(ACC_W-1){1'b1}}};
        end
    end

endmodule

### src/ellpack_sparse_matrix_vector_core.sv
// ELLPACK sparse matrix-vector core, one word handled at a time.
// Clear and vector write are done in the idle state. Append: fill-count read, then slot write.
// Multiply: per row a fill-count read, then per stored slot a slot read, and for a slot in
// range a multiply and an accumulate; then one result word per row in use, each held while
// the output is stalled. The walk over slots uses the shared multiply-accumulate unit and registered RAM reads.
// Reset (synchronous, active low): rows empty, drop flag clear, dimension 32.
module ellpack_sparse_matrix_vector_core #(
    parameter int MAX_ROWS      = ellp_pkg::MAX_ROWS_DEF,
    parameter int SLOTS_PER_ROW = ellp_pkg::SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  ellp_pkg::t_in_word          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output ellp_pkg::t_out_word         o_out_data,
    input  logic                        i_cfg_we,
    input  logic [ellp_pkg::NR_W-1:0]   i_cfg_data
);
    import ellp_pkg::*;

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int DW    = $clog2(MAX_ROWS + 1);
    localparam int FW    = $clog2(SLOTS_PER_ROW + 1);
    localparam int EDEP  = MAX_ROWS * SLOTS_PER_ROW;
    localparam int EW    = $clog2(EDEP);
    localparam int ENT_W = COL_W + VAL_W;
    localparam int CMPW  = (DW > NR_W) ? DW : NR_W;

    // slot address of row r, slot k
    function automatic logic [EW-1:0] slot_addr(input logic [RW-1:0] r,
                                                 input logic [FW-1:0] k);
        slot_addr = EW'(r) * EW'(SLOTS_PER_ROW) + EW'(k);
    endfunction

    t_state r_state, n_state;
    logic [NR_W-1:0]         r_n_rows;
    logic                    r_drop;
    logic [MAX_ROWS-1:0]     r_fill_vld;
    logic [MAX_ROWS-1:0]     r_acc_vld;
    logic                    r_mul_xa;
    logic [RW-1:0]           r_i, n_i;
    logic [FW-1:0]           r_k, n_k;
    logic [FW-1:0]           r_f, n_f;

    logic [RW-1:0]           r_row;
    logic [COL_W-1:0]        r_app_col;
    logic signed [VAL_W-1:0] r_app_val;
    logic signed [VAL_W-1:0] r_val;
    logic [RW-1:0]           r_acc_addr;
    t_out_word               r_out;

    logic                    in_acc;
    logic                    row_ok;
    logic                    vidx_ok;
    logic                    is_app;
    logic                    is_mul;
    logic [CMPW-1:0]         nr_x;
    logic [DW-1:0]           dim;
    logic [DW-1:0]           i_plus;
    logic                    last_row;
    logic                    last_slot;
    logic [CMPW-1:0]         r_i_x;

    // RAM ports
    logic                    fill_we;
    logic [RW-1:0]           fill_idx;
    logic [FW-1:0]           fill_rdata;
    logic [FW-1:0]           fill_cur;
    logic                    ent_we;
    logic [EW-1:0]           ent_waddr;
    logic [EW-1:0]           ent_raddr;
    logic [ENT_W-1:0]        ent_rdata;
    logic [COL_W-1:0]        ent_col;
    logic signed [VAL_W-1:0] ent_val;
    logic                    col_ok;
    logic [RW-1:0]           col_a;
    logic                    vec_we;
    logic [RW-1:0]           vec_waddr;
    logic [RW-1:0]           vec_raddr;
    logic [VAL_W-1:0]        vec_rdata;
    logic                    acc_we;
    logic [RW-1:0]           acc_raddr;
    logic [ACC_W-1:0]        acc_rdata;
    logic signed [ACC_W-1:0] acc_cur;
    logic signed [ACC_W-1:0] mac_sum;
    t_mac_ctl                mac_ctl;

    // handshake and input decode
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign row_ok     = CMPW'(i_in_data.row) < CMPW'(MAX_ROWS);
    assign vidx_ok    = CMPW'(i_in_data.vec_index) < CMPW'(MAX_ROWS);
    assign is_app     = row_ok && ((i_in_data.op == OP_APPEND) ||
                        ((i_in_data.op == OP_APPEND_NZ) && (i_in_data.value != '0)));
    assign is_mul     = (i_in_data.op == OP_MUL_AX) || (i_in_data.op == OP_MUL_XA);

    // dimension in use, clamped to 1..MAX_ROWS
    always_comb begin
        nr_x = CMPW'(r_n_rows);
        if (nr_x == '0) begin
            dim = DW'(1);
        end else if (nr_x > CMPW'(MAX_ROWS)) begin
            dim = DW'(MAX_ROWS);
        end else begin
            dim = DW'(nr_x);
        end
    end

    assign i_plus    = DW'(r_i) + DW'(1);
    assign last_row  = (i_plus == dim);
    assign last_slot = (FW'(r_k + 1'b1) == r_f);
    assign r_i_x     = CMPW'(r_i);

    // fill count of the row being looked at
    assign fill_idx = ((r_state == S_APP_RD) || (r_state == S_APP_WR)) ? r_row : r_i;
    assign fill_cur = r_fill_vld[fill_idx] ? fill_rdata : '0;

    // stored slot fields
    assign ent_col = ent_rdata[ENT_W-1:VAL_W];
    assign ent_val = ent_rdata[VAL_W-1:0];
    assign col_ok  = CMPW'(ent_col) < CMPW'(dim);
    assign col_a   = RW'(CMPW'(ent_col));

    assign acc_cur = r_acc_vld[r_i] ? acc_rdata : '0;

    // next state and counters
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_k     = r_k;
        n_f     = r_f;
        unique case (r_state)
            S_IDLE: begin
                n_i = '0;
                if (in_acc && is_app) begin
                    n_state = S_APP_RD;
                end else if (in_acc && is_mul) begin
                    n_state = S_ROW_RD;
                end
            end
            S_APP_RD: n_state = S_APP_WR;
            S_APP_WR: n_state = S_IDLE;
            S_ROW_RD: n_state = S_ROW_WT;
            S_ROW_WT: begin
                n_f = fill_cur;
                n_k = '0;
                if (fill_cur != '0) begin
                    n_state = S_ENT_RD;
                end else if (last_row) begin
                    n_i     = '0;
                    n_state = S_OUT_RD;
                end else begin
                    n_i     = RW'(i_plus);
                    n_state = S_ROW_RD;
                end
            end
            S_ENT_RD: n_state = S_ENT_WT;
            S_ENT_WT, S_ACC: begin
                if ((r_state == S_ENT_WT) && col_ok) begin
                    n_state = S_MUL;
                end else if (!last_slot) begin
                    n_k     = FW'(r_k + 1'b1);
                    n_state = S_ENT_RD;
                end else if (last_row) begin
                    n_i     = '0;
                    n_state = S_OUT_RD;
                end else begin
                    n_i     = RW'(i_plus);
                    n_state = S_ROW_RD;
                end
            end
            S_MUL:    n_state = S_ACC;
            S_OUT_RD: n_state = S_OUT_WT;
            S_OUT_WT: n_state = S_OUT_HOLD;
            S_OUT_HOLD: begin
                if (!i_out_stall) begin
                    if (last_row) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = RW'(i_plus);
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // RAM and unit controls
    always_comb begin
        fill_we   = 1'b0;
        ent_we    = 1'b0;
        ent_waddr = slot_addr(r_row, fill_cur);
        ent_raddr = slot_addr(r_i, r_k);
        vec_we    = 1'b0;
        vec_waddr = RW'(CMPW'(i_in_data.vec_index));
        vec_raddr = r_i;
        acc_we    = 1'b0;
        acc_raddr = r_i;
        mac_ctl   = '{mul_en: 1'b0, acc_vld: r_acc_vld[r_acc_addr]};
        unique case (r_state)
            S_IDLE: begin
                vec_we = in_acc && (i_in_data.op == OP_WR_VEC) && vidx_ok;
            end
            S_APP_WR: begin
                fill_we = (fill_cur < FW'(SLOTS_PER_ROW));
                ent_we  = fill_we;
            end
            S_ENT_WT: begin
                vec_raddr = r_mul_xa ? r_i : col_a;
                acc_raddr = r_mul_xa ? col_a : r_i;
            end
            S_MUL: begin
                mac_ctl.mul_en = 1'b1;
            end
            S_ACC: begin
                acc_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_n_rows   <= N_ROWS_RST;
            r_drop     <= 1'b0;
            r_fill_vld <= '0;
            r_acc_vld  <= '0;
            r_mul_xa   <= 1'b0;
            r_i        <= '0;
            r_k        <= '0;
            r_f        <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_k     <= n_k;
            r_f     <= n_f;
            if (i_cfg_we) begin
                r_n_rows <= i_cfg_data;
            end
            if (in_acc && (i_in_data.op == OP_CLEAR)) begin
                r_fill_vld <= '0;
                r_drop     <= 1'b0;
            end
            if (in_acc && is_mul) begin
                r_acc_vld <= '0;
                r_mul_xa  <= (i_in_data.op == OP_MUL_XA);
            end
            // full row: word dropped, flag sticks
            if (r_state == S_APP_WR) begin
                if (fill_we) begin
                    r_fill_vld[r_row] <= 1'b1;
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (acc_we) begin
                r_acc_vld[r_acc_addr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_row     <= RW'(CMPW'(i_in_data.row));
            r_app_col <= i_in_data.col;
            r_app_val <= i_in_data.value;
        end
        if (r_state == S_ENT_WT) begin
            r_val      <= ent_val;
            r_acc_addr <= r_mul_xa ? col_a : r_i;
        end
        if (r_state == S_OUT_WT) begin
            r_out.out_index <= r_i_x[4:0];
            r_out.out_value <= sat32(acc_cur);
            r_out.last      <= last_row;
            r_out.dropped   <= r_drop;
        end
    end

    assign o_out_valid = (r_state == S_OUT_HOLD);
    assign o_out_data  = r_out;

    // fill counts per row
    ellp_ram #(.WIDTH(FW), .DEPTH(MAX_ROWS)) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (fill_we),
        .i_waddr (r_row),
        .i_wdata (FW'(fill_cur + 1'b1)),
        .i_raddr (fill_idx),
        .o_rdata (fill_rdata)
    );

    // slot store: column over value
    ellp_ram #(.WIDTH(ENT_W), .DEPTH(EDEP)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata ({r_app_col, r_app_val}),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    // vector store
    ellp_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ROWS)) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (vec_we),
        .i_waddr (vec_waddr),
        .i_wdata (i_in_data.value),
        .i_raddr (vec_raddr),
        .o_rdata (vec_rdata)
    );

    // accumulators, cleared per run through the valid bits
    ellp_ram #(.WIDTH(ACC_W), .DEPTH(MAX_ROWS)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (r_acc_addr),
        .i_wdata (mac_sum),
        .i_raddr (acc_raddr),
        .o_rdata (acc_rdata)
    );

    // shared multiply-accumulate unit
    ellp_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (mac_ctl),
        .i_a   (vec_rdata),
        .i_b   (r_val),
        .i_acc (acc_rdata),
        .o_sum (mac_sum)
    );

endmodule

### tb/ellpack_sparse_matrix_vector_core_tb.sv
`timescale 1ns / 1ps

module ellpack_sparse_matrix_vector_core_tb;
    import ellp_pkg::*;

    // spare op codes, ignored by the block
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    localparam logic [VAL_W-1:0] Q_ONE = 32'h0001_0000;
    localparam logic [VAL_W-1:0] V_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] V_MIN = 32'h8000_0000;

    localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_LO = -ACC_HI - 1;
    localparam longint Q_HI   = 64'sd2147483647;
    localparam longint Q_LO   = -64'sd2147483648;

    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 500;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_word   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_word  o_out_data;
    logic       i_cfg_we;
    logic [NR_W-1:0] i_cfg_data;

    // shadow copy of the matrix, vector and register
    logic signed [VAL_W-1:0] ent_val [MAX_ROWS_DEF][SLOTS_DEF];
    logic [COL_W-1:0]        ent_col [MAX_ROWS_DEF][SLOTS_DEF];
    int                      row_cnt [MAX_ROWS_DEF];
    logic signed [VAL_W-1:0] x_elem  [MAX_ROWS_DEF];
    logic                    drop_sticky;
    logic [NR_W-1:0]         dim_reg;

    // result vector elements still to come out of the block
    t_out_word pending_elems[$];

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_req;
    int hold_seen;
    int hold_left;
    int fail_cnt;
    int words_in;
    int mults_in;
    int drops_seen;
    int elems_checked;

    ellpack_sparse_matrix_vector_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    function automatic int eff_dim();
        int d;
        d = int'(dim_reg);
        if (d == 0) d = 1;
        if (d > MAX_ROWS_DEF) d = MAX_ROWS_DEF;
        return d;
    endfunction

    // exact product, floored back to Q16.16
    function automatic longint q16_mul(input logic signed [VAL_W-1:0] a,
                                       input logic signed [VAL_W-1:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> FRAC_BITS;
    endfunction

    function automatic longint acc_sat(input longint a, input longint t);
        longint s;
        s = a + t;
        if (s > ACC_HI) s = ACC_HI;
        if (s < ACC_LO) s = ACC_LO;
        return s;
    endfunction

    function automatic logic signed [VAL_W-1:0] clamp_q16(input longint a);
        if (a > Q_HI) return V_MAX;
        if (a < Q_LO) return V_MIN;
        return a[VAL_W-1:0];
    endfunction

    task automatic store_entry(input t_in_word w);
        if (row_cnt[w.row] >= SLOTS_DEF) begin
            drop_sticky = 1'b1;
            drops_seen++;
        end else begin
            ent_val[w.row][row_cnt[w.row]] = w.value;
            ent_col[w.row][row_cnt[w.row]] = w.col;
            row_cnt[w.row]++;
        end
    endtask

    // walk every stored slot of the rows in use and queue the result vector
    task automatic predict_product(input logic [2:0] op);
        longint    acc [MAX_ROWS_DEF];
        t_out_word e;
        int        n;
        int        c;
        n = eff_dim();
        foreach (acc[i]) acc[i] = 0;
        for (int i = 0; i < n; i++) begin
            for (int k = 0; k < row_cnt[i]; k++) begin
                c = ent_col[i][k];
                if (c < n) begin
                    if (op == OP_MUL_AX) begin
                        acc[i] = acc_sat(acc[i], q16_mul(x_elem[c], ent_val[i][k]));
                    end else begin
                        acc[c] = acc_sat(acc[c], q16_mul(x_elem[i], ent_val[i][k]));
                    end
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            e.out_index = 5'(i);
            e.out_value = clamp_q16(acc[i]);
            e.last      = (i == n - 1);
            e.dropped   = drop_sticky;
            pending_elems = {pending_elems, e};
        end
    endtask

    task automatic predict_word(input t_in_word w);
        case (w.op)
            OP_CLEAR: begin
                foreach (row_cnt[i]) row_cnt[i] = 0;
                drop_sticky = 1'b0;
            end
            OP_APPEND: begin
                store_entry(w);
            end
            OP_APPEND_NZ: begin
                if (w.value != 0) store_entry(w);
            end
            OP_WR_VEC: begin
                x_elem[w.vec_index] = w.value;
            end
            OP_MUL_AX, OP_MUL_XA: begin
                mults_in++;
                predict_product(w.op);
            end
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------
    // driving
    // ---------------------------------------------------------------

    function automatic t_in_word make_word(input logic [2:0] op, input int r,
                                           input int c, input int vi,
                                           input logic [VAL_W-1:0] v);
        t_in_word w;
        w.op        = op;
        w.row       = 5'(r);
        w.col       = 5'(c);
        w.vec_index = 5'(vi);
        w.value     = v;
        return w;
    endfunction

    // offer one word, with a random gap first, and wait for it to be taken
    task automatic send_word(input t_in_word w);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predict_word(w);
        words_in++;
    endtask

    // all results out, then a drain wait for a trailing append
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_elems.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_dim(input logic [NR_W-1:0] n);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= n;
        @(posedge i_clk);
        dim_reg = n;
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(9))
            0: return V_MAX;
            1: return V_MIN;
            2: return '0;
            3: return 32'hFFFF_FFFF;
            4, 5, 6: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            default: return $urandom();
        endcase
    endfunction

    // mostly rows in use, often up to the three lowest rows so they fill up
    function automatic int pick_row();
        int d;
        d = eff_dim();
        case ($urandom_range(9))
            0, 1, 2: return $urandom_range(0, 31);
            3, 4, 5: return $urandom_range(0, ((d < 3) ? d : 3) - 1);
            default: return $urandom_range(0, d - 1);
        endcase
    endfunction

    function automatic int pick_col();
        if ($urandom_range(4) == 0) return $urandom_range(0, 31);
        return $urandom_range(0, eff_dim() - 1);
    endfunction

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin : check_results
        t_out_word want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            elems_checked++;
            if (pending_elems.size() == 0) begin
                fail_cnt++;
                $error("result word with no element expected: index %0d value %0d",
                       o_out_data.out_index, o_out_data.out_value);
            end else begin
                want = pending_elems.pop_front();
                if (o_out_data.out_index !== want.out_index) begin
                    fail_cnt++;
                    $error("out_index: expected %0d, got %0d",
                           want.out_index, o_out_data.out_index);
                end
                if (o_out_data.out_value !== want.out_value) begin
                    fail_cnt++;
                    $error("out_value: expected %0d, got %0d",
                           want.out_value, o_out_data.out_value);
                end
                if (o_out_data.last !== want.last) begin
                    fail_cnt++;
                    $error("last: expected %0d, got %0d", want.last, o_out_data.last);
                end
                if (o_out_data.dropped !== want.dropped) begin
                    fail_cnt++;
                    $error("dropped: expected %0d, got %0d",
                           want.dropped, o_out_data.dropped);
                end
            end
        end
    end

    // receiver stall: a hold request turns into a long stall, else random stalls
    always @(posedge i_clk) begin : drive_stall
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // every vector element gets a value before any multiply reads it
    task automatic test_vector_load();
        for (int i = 0; i < MAX_ROWS_DEF; i++) begin
            send_word(make_word(OP_WR_VEC, $urandom, $urandom, i, rand_value()));
        end
    endtask

    task automatic test_directed_cases();
        send_word(make_word(OP_CLEAR, 0, 0, 0, 0));
        send_word(make_word(OP_APPEND, 0, 0, 0, Q_ONE));
        // zero skipped by the dense scan, zero kept by a plain append
        send_word(make_word(OP_APPEND_NZ, 0, 1, 0, 0));
        send_word(make_word(OP_APPEND_NZ, 0, 31, 0, V_MAX));
        send_word(make_word(OP_APPEND, 31, 31, 0, V_MIN));
        send_word(make_word(OP_APPEND, 1, 0, 0, 0));
        send_word(make_word(OP_WR_VEC, 0, 0, 2, V_MIN));
        send_word(make_word(OP_WR_VEC, 0, 0, 31, V_MAX));
        // eight huge products overflow the accumulator, the ninth hits a full row
        for (int i = 0; i <= SLOTS_DEF; i++) begin
            send_word(make_word(OP_APPEND, 2, 2, 0, V_MIN));
        end
        send_word(make_word(OP_MUL_AX, 0, 0, 0, 0));
        send_word(make_word(OP_MUL_XA, 0, 0, 0, 0));
        send_word(make_word(OP_SPARE_A, 5, 5, 5, V_MAX));
        send_word(make_word(OP_SPARE_B, 31, 31, 31, V_MIN));
        // clear empties rows and drops the sticky flag
        send_word(make_word(OP_CLEAR, 0, 0, 0, 0));
        send_word(make_word(OP_MUL_AX, 0, 0, 0, 0));
    endtask

    // dimension clamping, rows and columns past the dimension
    task automatic test_dimension_clamp();
        logic [NR_W-1:0] dims [6];
        dims = '{6'd3, 6'd0, 6'd63, 6'd1, 6'd33, 6'd32};
        send_word(make_word(OP_APPEND, 0, 0, 0, rand_value()));
        send_word(make_word(OP_APPEND, 0, 2, 0, rand_value()));
        send_word(make_word(OP_APPEND, 1, 1, 0, rand_value()));
        send_word(make_word(OP_APPEND, 2, 0, 0, rand_value()));
        send_word(make_word(OP_APPEND, 2, 31, 0, rand_value()));
        send_word(make_word(OP_APPEND, 5, 1, 0, rand_value()));
        foreach (dims[i]) begin
            set_dim(dims[i]);
            send_word(make_word(OP_MUL_AX, $urandom, $urandom, $urandom, $urandom));
            send_word(make_word(OP_MUL_XA, $urandom, $urandom, $urandom, $urandom));
        end
    endtask

    // jobs of loads, vector updates and a multiply, with some noise between
    task automatic test_random_traffic(input int n_items, input logic [NR_W-1:0] dim);
        int       sent;
        int       n_app;
        logic [2:0] op;
        logic [VAL_W-1:0] v;
        set_dim(dim);
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(7) == 0) begin
                send_word(make_word(OP_CLEAR, $urandom, $urandom, $urandom, $urandom));
                sent++;
            end
            n_app = $urandom_range(1, 12);
            repeat (n_app) begin
                op = ($urandom_range(3) == 0) ? OP_APPEND_NZ : OP_APPEND;
                v  = rand_value();
                if (op == OP_APPEND_NZ && $urandom_range(2) == 0) v = '0;
                send_word(make_word(op, pick_row(), pick_col(), $urandom, v));
            end
            sent += n_app;
            repeat ($urandom_range(0, 3)) begin
                send_word(make_word(OP_WR_VEC, $urandom, $urandom, $urandom, rand_value()));
                sent++;
            end
            if ($urandom_range(4) == 0) begin
                op = ($urandom_range(1) == 0) ? OP_SPARE_A : OP_SPARE_B;
                send_word(make_word(op, $urandom, $urandom, $urandom, $urandom));
            end
            op = ($urandom_range(1) == 0) ? OP_MUL_XA : OP_MUL_AX;
            send_word(make_word(op, $urandom, $urandom, $urandom, $urandom));
            sent++;
        end
    endtask

    // receiver holds off while multiplies keep coming, so the input backs up
    task automatic test_output_backpressure();
        hold_req++;
        for (int i = 0; i < 4; i++) begin
            send_word(make_word((i % 2) ? OP_MUL_XA : OP_MUL_AX, $urandom, $urandom,
                                $urandom, $urandom));
        end
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_stall <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_data  <= '0;
        foreach (row_cnt[i]) row_cnt[i] = 0;
        drop_sticky   = 1'b0;
        dim_reg       = N_ROWS_RST;
        hold_req      = 0;
        hold_seen     = 0;
        hold_left     = 0;
        fail_cnt      = 0;
        words_in      = 0;
        mults_in      = 0;
        drops_seen    = 0;
        elems_checked = 0;
        tx_idle_pct   = 28;
        rx_idle_pct   = 71;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_vector_load();
        test_directed_cases();
        test_dimension_clamp();
        test_random_traffic(45, 6'd4);

        tx_idle_pct = 71;
        rx_idle_pct = 28;
        test_random_traffic(45, 6'($urandom_range(2, 8)));

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(45, 6'($urandom_range(9, 31)));
        test_output_backpressure();

        wait_drained();
        $display("Covered %0d input words with %0d multiplies at dimensions 0..63;",
                 words_in, mults_in);
        $display("checked %0d result words, %0d appends hit a full row.",
                 elems_checked, drops_seen);
        if (fail_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // hard stop if the block hangs
    initial begin
        #(20_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
